>>> src/cau_pkg.sv
// Shared types, codes and saturation helpers for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

    localparam int WIDTH     = 16;
    localparam int FRAC_BITS = 12;
    localparam int CMD_W     = 4;
    localparam int PROD_W    = 2 * WIDTH;
    localparam int MAG_W     = 2 * WIDTH;
    localparam int QB        = WIDTH + 1;
    localparam int DIV_LAT   = QB + 1;
    localparam int REM_W     = MAG_W + QB;
    localparam int RND_W     = MAG_W - FRAC_BITS + 1;

    localparam logic [CMD_W-1:0] CMD_ADD  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIV  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_NEG  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CONJ = 4'd5;
    localparam logic [CMD_W-1:0] CMD_EQ   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_NE   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_GT   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_LT   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_GE   = 4'd10;
    localparam logic [CMD_W-1:0] CMD_LE   = 4'd11;

    localparam int CLS_W = 3;
    localparam logic [CLS_W-1:0] CLS_NONE   = 3'd0;
    localparam logic [CLS_W-1:0] CLS_SIMPLE = 3'd1;
    localparam logic [CLS_W-1:0] CLS_MUL    = 3'd2;
    localparam logic [CLS_W-1:0] CLS_DIV    = 3'd3;
    localparam logic [CLS_W-1:0] CLS_CMP    = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [WIDTH-1:0] a_re;
        logic signed [WIDTH-1:0] a_im;
        logic signed [WIDTH-1:0] b_re;
        logic signed [WIDTH-1:0] b_im;
    } in_word_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] res_re;
        logic signed [WIDTH-1:0] res_im;
        logic                    cmp_true;
        logic [1:0]              status;
    } out_word_t;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        in_word_t         op;
    } item_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] val;
        logic                    sat;
    } part_t;

    // clip a sign-magnitude value into the WIDTH-bit range
    function automatic part_t pack_sm(input logic neg, input logic [RND_W-1:0] m);
        part_t            p;
        logic [RND_W-1:0] lim;
        logic [RND_W-1:0] mm;
        lim = (RND_W'(1) << (WIDTH - 1)) - RND_W'(!neg);
        if (m > lim)
        begin
            mm    = lim;
            p.sat = 1'b1;
        end
        else
        begin
            mm    = m;
            p.sat = 1'b0;
        end
        p.val = neg ? WIDTH'(RND_W'(0) - mm) : WIDTH'(mm);
        return p;
    endfunction

    // clip a one-bit-wider signed value into WIDTH bits
    function automatic part_t sat_s(input logic signed [WIDTH:0] x);
        part_t p;
        if (x[WIDTH] != x[WIDTH-1])
        begin
            p.sat = 1'b1;
            p.val = x[WIDTH] ? {1'b1, {(WIDTH-1){1'b0}}} : {1'b0, {(WIDTH-1){1'b1}}};
        end
        else
        begin
            p.sat = 1'b0;
            p.val = x[WIDTH-1:0];
        end
        return p;
    endfunction

endpackage
`default_nettype wire

>>> src/complex_arithmetic_unit_top.sv
// Complex arithmetic unit: add, sub, mul, div, neg, conj and compares on Q4.12 operands.
//
// Input side is a queue: drive in_word and raise push; the word is taken on an
// edge where push is high and full is low. Result side is a queue too: while
// empty is low the oldest result sits on out_word, and an edge with pop high
// takes it.
// One word is accepted every cycle while full is low. The taken word runs through
// the front queue, stage A, stage B and the pipelined divider into the result queue
// before empty falls; the divider, one quotient bit per stage, is passed by every
// command so results stay in order.
// The front queue holds two words, the result queue two more. When pop stays
// low the result queue fills, the back pipeline freezes in place, the front
// queue fills and full rises; nothing is dropped.
// Reset empties both queues and clears all pipeline valid bits.
`default_nettype none
module complex_arithmetic_unit_top
    import cau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_word_t in_word,
    output logic          empty,
    input  wire logic     pop,
    output out_word_t     out_word
);

    logic      q_pop;
    logic      q_empty;
    item_t     q_head;
    logic      oq_ready;
    logic      oq_push;
    out_word_t oq_word;

    cau_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_word (in_word),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_head  (q_head)
    );

    cau_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .oq_ready (oq_ready),
        .oq_push  (oq_push),
        .oq_word  (oq_word)
    );

    cau_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (oq_push),
        .word_in (oq_word),
        .ready   (oq_ready),
        .empty   (empty),
        .pop     (pop),
        .head    (out_word)
    );

endmodule
`default_nettype wire

>>> src/cau_front.sv
// Front end: accepts input words, classifies the command, queues them for the back end.
`default_nettype none
module cau_front
    import cau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_word_t in_word,
    input  wire logic     q_pop,
    output logic          q_empty,
    output item_t         q_head
);

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        do_push;
    logic        do_pop;
    item_t       dec;

    always_comb
    begin
        dec.op = in_word;
        if (in_word.cmd inside {CMD_ADD, CMD_SUB, CMD_NEG, CMD_CONJ})
            dec.cls = CLS_SIMPLE;
        else if (in_word.cmd == CMD_MUL)
            dec.cls = CLS_MUL;
        else if (in_word.cmd == CMD_DIV)
            dec.cls = CLS_DIV;
        else if (in_word.cmd inside {[CMD_EQ:CMD_LE]})
            dec.cls = CLS_CMP;
        else
            dec.cls = CLS_NONE;
    end

    assign full    = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign q_head  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && !q_empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= dec;
    end

endmodule
`default_nettype wire

>>> src/cau_div.sv
// Pipelined restoring divider lane: one quotient bit per stage.
`default_nettype none
module cau_div
    import cau_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [MAG_W-1:0] num,
    input  wire logic [MAG_W-1:0] den,
    output logic [QB-1:0]         quo,
    output logic                  ovf
);

    logic [REM_W-1:0] rem_reg [QB+1];
    logic [MAG_W-1:0] den_reg [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];
    logic             ovf_reg [QB+1];

    // quotient of num * 2^(FRAC_BITS+1) / den; ovf when it needs more than QB bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REM_W'(num) << (FRAC_BITS + 1);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= REM_W'(num) >= (REM_W'(den) << (WIDTH - FRAC_BITS));
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        localparam int SH = QB - 1 - k;
        logic [REM_W-1:0] dsh;
        logic             ge;

        assign dsh = REM_W'(den_reg[k]) << SH;
        assign ge  = rem_reg[k] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? rem_reg[k] - dsh : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= q_reg[k] | (QB'(ge) << SH);
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign quo = q_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule
`default_nettype wire

>>> src/cau_back.sv
// Back end: multiply, combine, divide and pack results; the whole pipe stalls as one.
`default_nettype none
module cau_back
    import cau_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_empty,
    input  wire item_t q_head,
    output logic       q_pop,
    input  wire logic  oq_ready,
    output logic       oq_push,
    output out_word_t  oq_word
);

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic             neg_re;
        logic             neg_im;
        logic [MAG_W-1:0] m_re;
        logic [MAG_W-1:0] m_im;
        part_t            s_re;
        part_t            s_im;
        logic             cmp;
        logic             den_zero;
    } side_t;

    logic adv;

    // stage A: products
    logic                     vld_a_reg;
    item_t                    a_item_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PROD_W-1:0] sq_ar_reg, sq_ai_reg, sq_br_reg, sq_bi_reg;

    // stage B: sums, magnitudes, simple results and compares
    logic             vld_b_reg;
    side_t            b_side_reg;
    logic [MAG_W-1:0] b_den_reg;
    side_t            b_side_next;
    logic [MAG_W-1:0] b_den_next;

    // delay line alongside the dividers
    side_t            side_reg [DIV_LAT];
    logic [DIV_LAT-1:0] vld_d_reg;

    logic [QB-1:0] q_re, q_im;
    logic          ovf_re, ovf_im;

    assign adv   = oq_ready;
    assign q_pop = adv && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_d_reg <= '0;
        end
        else if (adv)
        begin
            vld_a_reg <= !q_empty;
            vld_b_reg <= vld_a_reg;
            vld_d_reg <= {vld_d_reg[DIV_LAT-2:0], vld_b_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= q_head;
            p_rr_reg   <= PROD_W'(q_head.op.a_re) * PROD_W'(q_head.op.b_re);
            p_ii_reg   <= PROD_W'(q_head.op.a_im) * PROD_W'(q_head.op.b_im);
            p_ri_reg   <= PROD_W'(q_head.op.a_re) * PROD_W'(q_head.op.b_im);
            p_ir_reg   <= PROD_W'(q_head.op.a_im) * PROD_W'(q_head.op.b_re);
            sq_ar_reg  <= PROD_W'(q_head.op.a_re) * PROD_W'(q_head.op.a_re);
            sq_ai_reg  <= PROD_W'(q_head.op.a_im) * PROD_W'(q_head.op.a_im);
            sq_br_reg  <= PROD_W'(q_head.op.b_re) * PROD_W'(q_head.op.b_re);
            sq_bi_reg  <= PROD_W'(q_head.op.b_im) * PROD_W'(q_head.op.b_im);
        end
    end

    always_comb
    begin
        logic signed [PROD_W:0]  x_rr, x_ii, x_ri, x_ir, s_re, s_im, n_re, n_im;
        logic signed [WIDTH:0]   ar, ai, br, bi;
        logic [MAG_W-1:0]        ma, mb;
        x_rr = (PROD_W+1)'(p_rr_reg);
        x_ii = (PROD_W+1)'(p_ii_reg);
        x_ri = (PROD_W+1)'(p_ri_reg);
        x_ir = (PROD_W+1)'(p_ir_reg);
        if (a_item_reg.cls == CLS_MUL)
        begin
            s_re = x_rr - x_ii;
            s_im = x_ri + x_ir;
        end
        else
        begin
            s_re = x_rr + x_ii;
            s_im = x_ir - x_ri;
        end
        n_re = -s_re;
        n_im = -s_im;
        ma = MAG_W'($unsigned(sq_ar_reg)) + MAG_W'($unsigned(sq_ai_reg));
        mb = MAG_W'($unsigned(sq_br_reg)) + MAG_W'($unsigned(sq_bi_reg));
        ar = (WIDTH+1)'(a_item_reg.op.a_re);
        ai = (WIDTH+1)'(a_item_reg.op.a_im);
        br = (WIDTH+1)'(a_item_reg.op.b_re);
        bi = (WIDTH+1)'(a_item_reg.op.b_im);

        b_side_next.cls      = a_item_reg.cls;
        b_side_next.neg_re   = s_re[PROD_W];
        b_side_next.neg_im   = s_im[PROD_W];
        b_side_next.m_re     = s_re[PROD_W] ? n_re[MAG_W-1:0] : s_re[MAG_W-1:0];
        b_side_next.m_im     = s_im[PROD_W] ? n_im[MAG_W-1:0] : s_im[MAG_W-1:0];
        b_side_next.den_zero = (mb == '0);
        b_den_next           = mb;

        case (a_item_reg.op.cmd)
            CMD_ADD:
            begin
                b_side_next.s_re = sat_s(ar + br);
                b_side_next.s_im = sat_s(ai + bi);
            end
            CMD_SUB:
            begin
                b_side_next.s_re = sat_s(ar - br);
                b_side_next.s_im = sat_s(ai - bi);
            end
            CMD_NEG:
            begin
                b_side_next.s_re = sat_s(-ar);
                b_side_next.s_im = sat_s(-ai);
            end
            default:
            begin
                b_side_next.s_re = sat_s(ar);
                b_side_next.s_im = sat_s(-ai);
            end
        endcase

        case (a_item_reg.op.cmd)
            CMD_EQ:  b_side_next.cmp = (ar == br) && (ai == bi);
            CMD_NE:  b_side_next.cmp = ma != mb;
            CMD_GT:  b_side_next.cmp = ma > mb;
            CMD_LT:  b_side_next.cmp = ma < mb;
            CMD_GE:  b_side_next.cmp = ma >= mb;
            CMD_LE:  b_side_next.cmp = ma <= mb;
            default: b_side_next.cmp = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_side_reg <= b_side_next;
            b_den_reg  <= b_den_next;
            side_reg[0] <= b_side_reg;
            for (int i = 1; i < DIV_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    cau_div u_div_re (
        .clk (clk),
        .en  (adv),
        .num (b_side_reg.m_re),
        .den (b_den_reg),
        .quo (q_re),
        .ovf (ovf_re)
    );

    cau_div u_div_im (
        .clk (clk),
        .en  (adv),
        .num (b_side_reg.m_im),
        .den (b_den_reg),
        .quo (q_im),
        .ovf (ovf_im)
    );

    always_comb
    begin
        side_t          sd;
        logic [MAG_W:0] r_re, r_im;
        logic [QB:0]    d_re, d_im;
        logic [RND_W-1:0] g_re, g_im;
        part_t          p_re, p_im;
        sd   = side_reg[DIV_LAT-1];
        r_re = ({1'b0, sd.m_re} + (MAG_W+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r_im = ({1'b0, sd.m_im} + (MAG_W+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        // round half up from the extra quotient bit
        d_re = ({1'b0, q_re} + (QB+1)'(1)) >> 1;
        d_im = ({1'b0, q_im} + (QB+1)'(1)) >> 1;
        g_re = ovf_re ? (RND_W'(1) << WIDTH) : RND_W'(d_re);
        g_im = ovf_im ? (RND_W'(1) << WIDTH) : RND_W'(d_im);
        p_re = '0;
        p_im = '0;
        oq_word = '0;
        case (sd.cls)
            CLS_SIMPLE:
            begin
                p_re = sd.s_re;
                p_im = sd.s_im;
            end
            CLS_MUL:
            begin
                p_re = pack_sm(sd.neg_re, r_re[RND_W-1:0]);
                p_im = pack_sm(sd.neg_im, r_im[RND_W-1:0]);
            end
            CLS_DIV:
            begin
                if (!sd.den_zero)
                begin
                    p_re = pack_sm(sd.neg_re, g_re);
                    p_im = pack_sm(sd.neg_im, g_im);
                end
            end
            CLS_CMP:
            begin
                oq_word.cmp_true = sd.cmp;
            end
            default:
            begin
                p_re = '0;
            end
        endcase
        oq_word.res_re = p_re.val;
        oq_word.res_im = p_im.val;
        if (sd.cls == CLS_DIV && sd.den_zero)
            oq_word.status = ST_DIVZ;
        else if (p_re.sat || p_im.sat)
            oq_word.status = ST_SAT;
        else
            oq_word.status = ST_OK;
    end

    assign oq_push = adv && vld_d_reg[DIV_LAT-1];

endmodule
`default_nettype wire

>>> src/cau_outq.sv
// Two-word result queue between the back end and the result port.
`default_nettype none
module cau_outq
    import cau_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_in,
    input  wire out_word_t word_in,
    output logic           ready,
    output logic           empty,
    input  wire logic      pop,
    output out_word_t      head
);

    out_word_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign empty   = (cnt_reg == 2'd0);
    assign do_pop  = pop && !empty;
    assign ready   = (cnt_reg != 2'd2) || do_pop;
    assign do_push = push_in && ready;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= word_in;
    end

endmodule
`default_nettype wire

>>> tb/complex_arithmetic_unit_top_test.sv
// Self-checking testbench for the complex arithmetic unit: directed table plus random words.
`timescale 1ns / 100ps
`default_nettype none
module complex_arithmetic_unit_top_test;
    import cau_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_WORDS   = 1950;
    localparam logic signed [WIDTH-1:0] SMAX = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic signed [WIDTH-1:0] SMIN = {1'b1, {(WIDTH-1){1'b0}}};

    typedef struct {
        in_word_t  op;
        logic      has_exp;
        out_word_t exp;
    } vec_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_word_t  in_word;
    logic      empty;
    logic      pop;
    out_word_t out_word;

    out_word_t pending_results[$];
    vec_t      vectors[$];
    int        errors;
    int        quiet_cycles;
    logic      no_idle;
    logic      stim_done;

    complex_arithmetic_unit_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_word  (in_word),
        .empty    (empty),
        .pop      (pop),
        .out_word (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // saturate a wide signed value into the result field
    function automatic logic [WIDTH-1:0] clip(input longint x, inout logic sat);
        if (x > longint'(SMAX))
        begin
            sat = 1'b1;
            return SMAX;
        end
        if (x < longint'(SMIN))
        begin
            sat = 1'b1;
            return SMIN;
        end
        return x[WIDTH-1:0];
    endfunction

    // round to nearest, ties away from zero, of num * 2^FRAC_BITS / den
    function automatic longint round_div(input longint num, input longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = ((m << (FRAC_BITS + 1)) / den + 1) >>> 1;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint round_mul(input longint p);
        longint m;
        longint q;
        m = (p < 0) ? -p : p;
        q = (m + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (p < 0) ? -q : q;
    endfunction

    function automatic out_word_t alu_result(input in_word_t w);
        out_word_t r;
        longint    ar, ai, br, bi, ma, mb, den;
        logic      sat;
        ar = w.a_re;
        ai = w.a_im;
        br = w.b_re;
        bi = w.b_im;
        ma = ar * ar + ai * ai;
        mb = br * br + bi * bi;
        sat = 1'b0;
        r = '0;
        case (w.cmd)
            CMD_ADD:
            begin
                r.res_re = clip(ar + br, sat);
                r.res_im = clip(ai + bi, sat);
            end
            CMD_SUB:
            begin
                r.res_re = clip(ar - br, sat);
                r.res_im = clip(ai - bi, sat);
            end
            CMD_MUL:
            begin
                r.res_re = clip(round_mul(ar * br - ai * bi), sat);
                r.res_im = clip(round_mul(ar * bi + br * ai), sat);
            end
            CMD_DIV:
            begin
                den = mb;
                if (den == 0)
                    r.status = ST_DIVZ;
                else
                begin
                    r.res_re = clip(round_div(ar * br + ai * bi, den), sat);
                    r.res_im = clip(round_div(ai * br - ar * bi, den), sat);
                end
            end
            CMD_NEG:
            begin
                r.res_re = clip(-ar, sat);
                r.res_im = clip(-ai, sat);
            end
            CMD_CONJ:
            begin
                r.res_re = clip(ar, sat);
                r.res_im = clip(-ai, sat);
            end
            CMD_EQ: r.cmp_true = (ar == br) && (ai == bi);
            CMD_NE: r.cmp_true = ma != mb;
            CMD_GT: r.cmp_true = ma > mb;
            CMD_LT: r.cmp_true = ma < mb;
            CMD_GE: r.cmp_true = ma >= mb;
            CMD_LE: r.cmp_true = ma <= mb;
            default: ;
        endcase
        if (sat && r.status == ST_OK)
            r.status = ST_SAT;
        return r;
    endfunction

    function automatic logic [WIDTH-1:0] rand_part();
        case ($urandom_range(0, 7))
            0: return SMAX;
            1: return SMIN;
            2: return '0;
            3: return WIDTH'($urandom_range(0, 16)) - WIDTH'(8);
            4: return WIDTH'($urandom_range(0, 8192)) - WIDTH'(4096);
            default: return WIDTH'($urandom);
        endcase
    endfunction

    function automatic vec_t row(input logic [CMD_W-1:0] c, input logic [WIDTH-1:0] ar,
                                 input logic [WIDTH-1:0] ai, input logic [WIDTH-1:0] br,
                                 input logic [WIDTH-1:0] bi, input logic h,
                                 input logic [WIDTH-1:0] er, input logic [WIDTH-1:0] ei,
                                 input logic ec, input logic [1:0] es);
        vec_t v;
        v.op      = '{cmd: c, a_re: ar, a_im: ai, b_re: br, b_im: bi};
        v.has_exp = h;
        v.exp     = '{res_re: er, res_im: ei, cmp_true: ec, status: es};
        return v;
    endfunction

    // called at a falling edge; leaves push high after the word is taken
    task automatic send_word(input in_word_t w);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 8)
            begin
                push <= 1'b0;
                @(negedge clk);
            end
        end
        push    <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // sender: directed table, then random words
    initial
    begin
        vec_t     v;
        in_word_t w;
        errors    = 0;
        no_idle   = 1'b0;
        stim_done = 1'b0;
        rst_n     = 1'b0;
        push      = 1'b0;
        in_word   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        vectors.push_back(row(CMD_ADD, 0, 0, 0, 0, 1, 0, 0, 0, ST_OK));
        vectors.push_back(row(CMD_ADD, SMAX, SMIN, SMAX, SMIN, 1, SMAX, SMIN, 0, ST_SAT));
        vectors.push_back(row(CMD_SUB, SMIN, SMAX, SMAX, SMIN, 1, SMIN, SMAX, 0, ST_SAT));
        vectors.push_back(row(CMD_MUL, SMIN, SMIN, SMIN, SMIN, 0, 0, 0, 0, ST_OK));
        vectors.push_back(row(CMD_MUL, SMAX, SMAX, SMAX, SMIN, 0, 0, 0, 0, ST_OK));
        vectors.push_back(row(CMD_MUL, 4096, 0, 4096, 0, 1, 4096, 0, 0, ST_OK));
        vectors.push_back(row(CMD_DIV, 1234, 77, 0, 0, 1, 0, 0, 0, ST_DIVZ));
        vectors.push_back(row(CMD_DIV, SMAX, SMAX, 1, 0, 0, 0, 0, 0, ST_OK));
        vectors.push_back(row(CMD_DIV, SMIN, 1, SMIN, SMIN, 0, 0, 0, 0, ST_OK));
        vectors.push_back(row(CMD_DIV, 4096, 4096, 4096, 0, 1, 4096, 4096, 0, ST_OK));
        vectors.push_back(row(CMD_NEG, SMIN, SMIN, 0, 0, 1, SMAX, SMAX, 0, ST_SAT));
        vectors.push_back(row(CMD_NEG, SMAX, 5, 0, 0, 1, SMIN + 1, -5, 0, ST_OK));
        vectors.push_back(row(CMD_CONJ, SMIN, SMIN, 0, 0, 1, SMIN, SMAX, 0, ST_SAT));
        vectors.push_back(row(CMD_CONJ, 3, SMAX, 0, 0, 1, 3, SMIN + 1, 0, ST_OK));
        vectors.push_back(row(CMD_EQ, SMIN, SMAX, SMIN, SMAX, 1, 0, 0, 1, ST_OK));
        vectors.push_back(row(CMD_EQ, 3, 4, 4, 3, 1, 0, 0, 0, ST_OK));
        vectors.push_back(row(CMD_NE, 3, 4, 4, 3, 1, 0, 0, 0, ST_OK));
        vectors.push_back(row(CMD_GT, SMIN, SMIN, SMAX, SMAX, 1, 0, 0, 1, ST_OK));
        vectors.push_back(row(CMD_LT, SMIN, SMIN, SMAX, SMAX, 1, 0, 0, 0, ST_OK));
        vectors.push_back(row(CMD_GE, 5, 0, 0, -5, 1, 0, 0, 1, ST_OK));
        vectors.push_back(row(CMD_LE, 6, 0, 0, -5, 1, 0, 0, 0, ST_OK));
        vectors.push_back(row(4'd12, 1, 2, 3, 4, 1, 0, 0, 0, ST_OK));
        vectors.push_back(row(4'd15, SMIN, SMIN, SMIN, SMIN, 1, 0, 0, 0, ST_OK));

        foreach (vectors[i])
        begin
            v = vectors[i];
            pending_results.push_back(v.has_exp ? v.exp : alu_result(v.op));
            send_word(v.op);
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // hold both sides busy through a long middle stretch
            no_idle = (n >= 800 && n < 1100);
            w.cmd  = ($urandom_range(0, 19) == 0) ? CMD_W'($urandom_range(12, 15))
                                                   : CMD_W'($urandom_range(0, 11));
            w.a_re = rand_part();
            w.a_im = rand_part();
            if ($urandom_range(0, 9) == 0)
            begin
                w.b_re = w.a_re;
                w.b_im = w.a_im;
            end
            else
            begin
                w.b_re = rand_part();
                w.b_im = rand_part();
            end
            pending_results.push_back(alu_result(w));
            send_word(w);
        end
        push      <= 1'b0;
        no_idle   = 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random pop, drive at falling edge
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop <= no_idle || ($urandom_range(0, 99) >= 8);
        end
    end

    // checker and watchdog on rising edges
    initial
    begin
        out_word_t e;
        quiet_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            quiet_cycles++;
            if (push && !full)
                quiet_cycles = 0;
            if (pop && !empty)
            begin
                quiet_cycles = 0;
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (out_word.res_re !== e.res_re)
                    begin
                        $error("res_re expected %0d actual %0d", e.res_re, out_word.res_re);
                        errors++;
                    end
                    if (out_word.res_im !== e.res_im)
                    begin
                        $error("res_im expected %0d actual %0d", e.res_im, out_word.res_im);
                        errors++;
                    end
                    if (out_word.cmp_true !== e.cmp_true)
                    begin
                        $error("cmp_true expected %0d actual %0d", e.cmp_true,
                               out_word.cmp_true);
                        errors++;
                    end
                    if (out_word.status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, out_word.status);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // end of run: drain, settle, then report
    initial
    begin
        @(posedge rst_n);
        wait (stim_done);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && empty)
        begin
            $display("PASS");
        end
        else
        begin
            if (!empty)
                $error("result word left over at end of run");
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
